>>> rtl/core/gcdq_pkg.sv
`timescale 1ns / 1ps

package gcdq_pkg;

    localparam int PIN_COUNT_DEFAULT = 8;
    localparam int LEVEL_W           = 8;
    localparam int PIN_W             = 3;
    localparam int DELAY_W           = 10;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 10;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_MASK   = 2'd0,
        CFG_EVENT_ENABLE = 2'd1,
        CFG_DELAY_TICKS  = 2'd2
    } cfg_idx_t;

    // Per-lane result of one tick.
    typedef struct packed {
        logic fire;
        logic level;
    } lane_evt_t;

    function automatic logic [PIN_W-1:0] lowest_set(input logic [LEVEL_W-1:0] v);
        logic [PIN_W-1:0] idx;
        idx = '0;
        for (int i = LEVEL_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = PIN_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/core/gcdq_lane.sv
`timescale 1ns / 1ps

module gcdq_lane (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         tick,
    input  logic                         level,
    input  logic                         in_en,
    input  logic                         evt_en,
    input  logic [gcdq_pkg::DELAY_W-1:0] delay,
    output gcdq_pkg::lane_evt_t          evt
);

    logic                         prev_reg, prev_next;
    logic                         pend_reg, pend_next;
    logic                         cap_reg, cap_next;
    logic [gcdq_pkg::DELAY_W-1:0] timer_reg, timer_next;

    logic expire;
    logic pend_after;
    logic capture;

    // timer <= 1 means this tick ends the debounce window
    assign expire     = pend_reg && (timer_reg <= gcdq_pkg::DELAY_W'(1));
    assign pend_after = pend_reg && !expire;
    assign capture    = (level ^ prev_reg) && in_en && !pend_after;

    assign evt.fire  = tick && expire && (level == cap_reg) && evt_en;
    assign evt.level = cap_reg;

    always_comb begin
        prev_next  = prev_reg;
        pend_next  = pend_reg;
        cap_next   = cap_reg;
        timer_next = timer_reg;
        if (tick) begin
            prev_next = level;
            pend_next = pend_after || capture;
            if (capture) begin
                cap_next   = level;
                timer_next = delay;
            end else if (pend_after) begin
                timer_next = timer_reg - gcdq_pkg::DELAY_W'(1);
            end else if (expire) begin
                timer_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            cap_reg   <= 1'b0;
            timer_reg <= '0;
        end else begin
            prev_reg  <= prev_next;
            pend_reg  <= pend_next;
            cap_reg   <= cap_next;
            timer_reg <= timer_next;
        end
    end

endmodule

>>> rtl/core/gcdq_merge.sv
`timescale 1ns / 1ps

module gcdq_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [gcdq_pkg::LEVEL_W-1:0] fire_vec,
    input  logic [gcdq_pkg::LEVEL_W-1:0] level_vec,
    output logic                         can_load,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gcdq_pkg::PIN_W-1:0]   m_pin_number,
    output logic                         m_pin_level,
    output logic                         m_last_event
);

    logic [gcdq_pkg::LEVEL_W-1:0] pend_reg, pend_next;
    logic [gcdq_pkg::LEVEL_W-1:0] lvl_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [gcdq_pkg::PIN_W-1:0]   out_pin_reg;
    logic                         out_lvl_reg;
    logic                         out_last_reg;

    logic                         move;
    logic [gcdq_pkg::PIN_W-1:0]   sel;
    logic [gcdq_pkg::LEVEL_W-1:0] rest;

    assign sel      = gcdq_pkg::lowest_set(pend_reg);
    assign rest     = pend_reg & (pend_reg - gcdq_pkg::LEVEL_W'(1));
    assign move     = (pend_reg != '0) && (!out_valid_reg || m_ready);
    // a new tick may land once the current tick's final item is moving out
    assign can_load = (pend_reg == '0) || (move && (rest == '0));

    always_comb begin
        pend_next = pend_reg;
        if (load) begin
            pend_next = fire_vec;
        end else if (move) begin
            pend_next = rest;
        end
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lvl_reg <= level_vec;
        end
        if (move) begin
            out_pin_reg  <= sel;
            out_lvl_reg  <= lvl_reg[sel];
            out_last_reg <= (rest == '0);
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pin_number = out_pin_reg;
    assign m_pin_level  = out_lvl_reg;
    assign m_last_event = out_last_reg;

endmodule

>>> rtl/core/gpio_change_debounce_qualifier_core.sv
`timescale 1ns / 1ps

// Change-interrupt debounce qualifier. Each input item is one tick with the
// levels of up to eight pins; each pin has its own lane holding its previous
// level, pending flag, captured level and debounce timer, all updated in the
// cycle the tick is accepted. Confirmed changes are queued and sent one item
// per cycle, unless a low m_ready holds the output, in ascending pin order,
// m_last_event marking the final item of a tick. The next tick is accepted as
// soon as the previous tick's last item has moved into the output register, so
// ticks with no events go through one a cycle while no earlier items wait.
// Configuration: cfg_index 0 input_mask, 1 event_enable, 2 delay_ticks
// (reset 50); other indexes are ignored.

module gpio_change_debounce_qualifier_core #(
    parameter int PIN_COUNT = gcdq_pkg::PIN_COUNT_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gcdq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcdq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gcdq_pkg::LEVEL_W-1:0]    s_pin_levels,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gcdq_pkg::PIN_W-1:0]      m_pin_number,
    output logic                            m_pin_level,
    output logic                            m_last_event
);

    localparam int LANES = (PIN_COUNT < gcdq_pkg::LEVEL_W) ? PIN_COUNT : gcdq_pkg::LEVEL_W;

    logic [gcdq_pkg::LEVEL_W-1:0] input_mask_reg;
    logic [gcdq_pkg::LEVEL_W-1:0] event_enable_reg;
    logic [gcdq_pkg::DELAY_W-1:0] delay_ticks_reg;

    logic                         tick;
    logic                         can_load;
    logic [gcdq_pkg::LEVEL_W-1:0] fire_vec;
    logic [gcdq_pkg::LEVEL_W-1:0] level_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_mask_reg   <= '0;
            event_enable_reg <= '0;
            delay_ticks_reg  <= gcdq_pkg::DELAY_RESET;
        end else if (cfg_wr_en) begin
            unique case (gcdq_pkg::cfg_idx_t'(cfg_index))
                gcdq_pkg::CFG_INPUT_MASK: begin
                    input_mask_reg <= cfg_wdata[gcdq_pkg::LEVEL_W-1:0];
                end
                gcdq_pkg::CFG_EVENT_ENABLE: begin
                    event_enable_reg <= cfg_wdata[gcdq_pkg::LEVEL_W-1:0];
                end
                gcdq_pkg::CFG_DELAY_TICKS: begin
                    delay_ticks_reg <= cfg_wdata[gcdq_pkg::DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = can_load;
    assign tick    = s_valid && can_load;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        gcdq_pkg::lane_evt_t evt;

        gcdq_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tick    (tick),
            .level   (s_pin_levels[i]),
            .in_en   (input_mask_reg[i]),
            .evt_en  (event_enable_reg[i]),
            .delay   (delay_ticks_reg),
            .evt     (evt)
        );

        assign fire_vec[i]  = evt.fire;
        assign level_vec[i] = evt.level;
    end

    for (genvar i = LANES; i < gcdq_pkg::LEVEL_W; i++) begin : g_unused
        assign fire_vec[i]  = 1'b0;
        assign level_vec[i] = 1'b0;
    end

    gcdq_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (tick),
        .fire_vec     (fire_vec),
        .level_vec    (level_vec),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pin_number (m_pin_number),
        .m_pin_level  (m_pin_level),
        .m_last_event (m_last_event)
    );

endmodule
